// File: rtl/core/utx_pkg.sv
// Shared types, codes and helper functions for the 8N1 serial transmitter.
// No dependencies; the front end, back end and top level import this package.
package utx_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRESCALE_SELECT = 2'd0;
	localparam logic [1:0] CFG_BIT_TOP         = 2'd1;
	localparam logic [1:0] CFG_STOP_BIT_COUNT  = 2'd2;

	// Reset values of the configuration registers
	localparam logic [2:0] PRESCALE_SELECT_RST = 3'd0;
	localparam logic [7:0] BIT_TOP_RST         = 8'd0;
	localparam logic [3:0] STOP_BIT_COUNT_RST  = 4'd1;

	localparam logic [3:0] DATA_BITS     = 4'd8;
	localparam logic [3:0] MAX_STOP_BITS = 4'd8;

	// Item kind after classification
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SEND = 1'b1
	} op_t;

	// Frame phase of the transmitter
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	// Classified command held in the queue between front and back
	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} cmd_t;

	// Configuration write as it travels from the top level to the engine
	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	// Prescaler terminal count: divisor minus one; codes four and above divide by 1024
	function automatic logic [9:0] prescale_last(input logic [2:0] sel);
		logic [9:0] last;
		case (sel)
			3'd0: last = 10'd0;
			3'd1: last = 10'd7;
			3'd2: last = 10'd63;
			3'd3: last = 10'd255;
			default: last = 10'd1023;
		endcase
		return last;
	endfunction

	// Stop bits actually sent: zero means one, above eight means eight
	function automatic logic [3:0] stop_bits_used(input logic [3:0] cnt);
		logic [3:0] used;
		if (cnt == 4'd0) begin
			used = 4'd1;
		end else if (cnt > MAX_STOP_BITS) begin
			used = MAX_STOP_BITS;
		end else begin
			used = cnt;
		end
		return used;
	endfunction

endpackage

// File: rtl/core/utx_in_if.sv
// Input channel of the transmitter: valid/ready plus the item fields.
// Stand-alone interface, no dependencies.
interface utx_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// File: rtl/core/utx_out_if.sv
// Result channel of the transmitter: valid/ready plus the result fields.
// Stand-alone interface, no dependencies.
interface utx_out_if;
	logic valid;
	logic ready;
	logic tx_line;
	logic busy_res;
	logic send_refused;

	modport source (output valid, output tx_line, output busy_res, output send_refused,
		input ready);
	modport sink (input valid, input tx_line, input busy_res, input send_refused,
		output ready);
endinterface

// File: rtl/core/utx_front.sv
// Front end: takes input transfers, classifies them and queues them (two entries).
// Depends on utx_pkg and utx_in_if.
module utx_front import utx_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	utx_in_if.sink         item,
	output logic           q_valid,
	output cmd_t           q_cmd,
	input  logic           q_ready
);

	localparam logic [1:0] QDEPTH = 2'd2;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       cmd_in;

	// Classify the incoming item
	always_comb begin
		cmd_in.op        = item.kind ? OP_SEND : OP_TICK;
		cmd_in.data_byte = item.data_byte;
	end

	assign item.ready = (count_q != QDEPTH);
	assign push       = item.valid && item.ready;
	assign q_valid    = (count_q != 2'd0);
	assign pop        = q_valid && q_ready;
	assign q_cmd      = entry_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/utx_back.sv
// Back end: configuration registers, timebase, frame sequencer and result register.
// Depends on utx_pkg and utx_out_if.
module utx_back import utx_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_wr_t        cfg_wr,
	input  logic           q_valid,
	input  cmd_t           q_cmd,
	output logic           q_ready,
	utx_out_if.source      result
);

	// Configuration
	logic [2:0] prescale_select_q;
	logic [7:0] bit_top_q;
	logic [3:0] stop_bit_count_q;

	// Transmitter state
	phase_t     phase_q, phase_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] bits_left_q, bits_left_d;
	logic [9:0] pre_cnt_q, pre_cnt_d;
	logic [7:0] bit_tmr_q, bit_tmr_d;
	logic       line_q, line_d;
	logic       refused_d;
	logic       bit_end;

	// Result register
	logic res_valid_q;
	logic res_line_q;
	logic res_busy_q;
	logic res_refused_q;
	logic step;

	assign q_ready = !res_valid_q || result.ready;
	assign step    = q_valid && q_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_select_q <= PRESCALE_SELECT_RST;
			bit_top_q         <= BIT_TOP_RST;
			stop_bit_count_q  <= STOP_BIT_COUNT_RST;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				CFG_PRESCALE_SELECT: prescale_select_q <= cfg_wr.data[2:0];
				CFG_BIT_TOP:         bit_top_q         <= cfg_wr.data;
				CFG_STOP_BIT_COUNT:  stop_bit_count_q  <= cfg_wr.data[3:0];
				default: ;
			endcase
		end
	end

	// Next state for one command
	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		pre_cnt_d   = pre_cnt_q;
		bit_tmr_d   = bit_tmr_q;
		line_d      = line_q;
		refused_d   = 1'b0;
		bit_end     = 1'b0;

		case (q_cmd.op)
			OP_TICK: begin
				// prescaler, then bit timer on its wrap
				if (pre_cnt_q >= prescale_last(prescale_select_q)) begin
					pre_cnt_d = 10'd0;
					if (bit_tmr_q == bit_top_q) begin
						bit_tmr_d = 8'd0;
						bit_end   = 1'b1;
					end else begin
						bit_tmr_d = bit_tmr_q + 8'd1;
					end
				end else begin
					pre_cnt_d = pre_cnt_q + 10'd1;
				end

				// end of a bit time moves the frame on
				if (bit_end && (phase_q != PH_IDLE)) begin
					if (bits_left_q > 4'd1) begin
						bits_left_d = bits_left_q - 4'd1;
						if (phase_q == PH_DATA) begin
							shift_d = {1'b1, shift_q[7:1]};
							line_d  = shift_q[1];
						end
					end else begin
						case (phase_q)
							PH_START: begin
								phase_d     = PH_DATA;
								bits_left_d = DATA_BITS;
								line_d      = shift_q[0];
							end
							PH_DATA: begin
								phase_d     = PH_STOP;
								shift_d     = 8'hff;
								bits_left_d = stop_bits_used(stop_bit_count_q);
								line_d      = 1'b1;
							end
							default: begin
								phase_d     = PH_IDLE;
								bits_left_d = 4'd0;
								line_d      = 1'b1;
							end
						endcase
					end
				end
			end
			OP_SEND: begin
				if (phase_q != PH_IDLE) begin
					refused_d = 1'b1;
				end else begin
					// start bit; timebase restarts so it lasts a full bit time
					phase_d     = PH_START;
					shift_d     = q_cmd.data_byte;
					bits_left_d = 4'd1;
					pre_cnt_d   = 10'd0;
					bit_tmr_d   = 8'd0;
					line_d      = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= 8'hff;
			bits_left_q <= 4'd0;
			pre_cnt_q   <= 10'd0;
			bit_tmr_q   <= 8'd0;
			line_q      <= 1'b1;
		end else if (step) begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			pre_cnt_q   <= pre_cnt_d;
			bit_tmr_q   <= bit_tmr_d;
			line_q      <= line_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_ready) begin
			res_valid_q <= q_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_line_q    <= line_d;
			res_busy_q    <= (phase_d != PH_IDLE);
			res_refused_q <= refused_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.tx_line      = res_line_q;
	assign result.busy_res     = res_busy_q;
	assign result.send_refused = res_refused_q;

endmodule

// File: rtl/core/uart_tx_8n1_timed_top.sv
// 8N1 serial transmitter with programmable prescaler, bit time and stop bits.
// Throughput: one item per cycle while results are taken; one result transfer per item.
// Path: an item is written into the queue at its input transfer; the engine then steps it
// into the result register, and this step waits while the result stalls.
// Reset: asynchronous, clears queue, result register, frame state and registers.
// Depends on utx_pkg, utx_in_if, utx_out_if, utx_front and utx_back.
module uart_tx_8n1_timed_top import utx_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	utx_in_if.sink         item,
	utx_out_if.source      result,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);

	logic    q_valid;
	logic    q_ready;
	cmd_t    q_cmd;
	cfg_wr_t cfg_wr;

	// Configuration write bundle
	always_comb begin
		cfg_wr.we    = cfg_we;
		cfg_wr.index = cfg_index;
		cfg_wr.data  = cfg_data;
	end

	utx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_ready (q_ready)
	);

	utx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_ready (q_ready),
		.result  (result)
	);

endmodule
